// File: rtl/elf_segment_table_checker_assert.svh
// ----------------------------------------------------------------------------
// elf_segment_table_checker_assert.svh
// Assertion macros shared by the ELF segment table checker RTL.
// ----------------------------------------------------------------------------
`ifndef ELF_SEGMENT_TABLE_CHECKER_ASSERT_SVH
`define ELF_SEGMENT_TABLE_CHECKER_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define ESTC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ESTC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ESTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/estc_pkg.sv
// ----------------------------------------------------------------------------
// estc_pkg
// Types, field layout and status codes of the ELF segment table checker.
// ----------------------------------------------------------------------------
`default_nettype none

package estc_pkg;

   // Word widths
   localparam int REQ_DATA_W = 432;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Status codes
   typedef logic [3:0] status_type;
   localparam status_type ST_OK       = 4'd0;
   localparam status_type ST_IDENT    = 4'd1;
   localparam status_type ST_SIZES    = 4'd2;
   localparam status_type ST_TYPE     = 4'd3;
   localparam status_type ST_ENTRY    = 4'd4;
   localparam status_type ST_BELOW    = 4'd5;
   localparam status_type ST_UNSORTED = 4'd6;
   localparam status_type ST_ALIGN    = 4'd7;
   localparam status_type ST_OVERLAP  = 4'd8;
   localparam status_type ST_FILE     = 4'd9;
   localparam status_type ST_MEMSZ    = 4'd10;
   localparam status_type ST_END      = 4'd11;
   localparam status_type ST_ORDER    = 4'd12;

   // Configuration register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_MEM_LIMIT      = 2'd0;
   localparam csr_idx_type CSR_MIN_LOAD_ADDR  = 2'd1;
   localparam csr_idx_type CSR_TARGET_MACHINE = 2'd2;
   localparam csr_idx_type CSR_DATA_ENCODING  = 2'd3;

   // Item kinds
   localparam logic KIND_FILE_HEADER = 1'b0;
   localparam logic KIND_PROG_HEADER = 1'b1;

   // Header constants
   localparam logic [31:0] ELF_MAGIC          = 32'h464C_457F;
   localparam logic [7:0]  ELF_CLASS_64       = 8'd2;
   localparam logic [31:0] ELF_VERSION        = 32'd1;
   localparam logic [15:0] ELF_HEADER_SIZE    = 16'd64;
   localparam logic [15:0] ELF_PHDR_SIZE      = 16'd56;
   localparam logic [31:0] ELF_TYPE_EXEC      = 32'd2;
   localparam logic [31:0] PT_LOAD            = 32'd1;
   localparam logic [15:0] RESET_MACHINE      = 16'd62;
   localparam logic [1:0]  RESET_ENCODING     = 2'd1;

   // Request data word, first field in the highest bits
   typedef struct packed {
      logic [63:0] alignment;
      logic [63:0] memory_bytes;
      logic [63:0] file_bytes;
      logic [63:0] address;
      logic [15:0] machine;
      logic [31:0] type_code;
      logic [15:0] entry_count;
      logic [15:0] entry_size;
      logic [15:0] header_size;
      logic [31:0] format_version;
      logic [47:0] ident_word;
   } req_fields_type;

   // Result register contents
   typedef struct packed {
      status_type  status;
      logic        done_res;
      logic [63:0] entry_point;
      logic [63:0] end_address;
   } rsp_fields_type;

endpackage

`default_nettype wire

// File: rtl/elf_segment_table_checker.sv
// ----------------------------------------------------------------------------
// elf_segment_table_checker
// Streams an ELF64 file header and its program headers through load checks.
//
//   channel  dir  payload                                        handshake
//   req_     in   tuser kind, tdata header/segment fields         tvalid/tready
//   rsp_     out  tlast done_res, tdata status/entry/end address  tvalid/tready
//   csr_     in   index, 64-bit write data                        write enable
//
// One item per cycle sustained while rsp_ does not stall; an accepted item is
// registered in the input register, then passes the check/state-update step into
// the result register, whose word is valid on rsp_ until it is taken.
// The single state-update step between the two registers sets the rate.
// Synchronous active-high reset clears the valids of both pipeline stages and all checker state.
// Stalls on rsp_ back up through the result register to req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "elf_segment_table_checker_assert.svh"

module elf_segment_table_checker
   import estc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // ident_word, format_version,
                                                   // header_size, entry_size,
                                                   // entry_count, type_code,
                                                   // machine, address, file_bytes,
                                                   // memory_bytes, alignment
   input  wire logic                  req_tuser,  // kind
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // status, entry_point,
                                                   // end_address, zero pad
   output logic                       rsp_tlast,  // done_res
   // configuration port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [63:0] mem_limit_ff;
   logic [63:0] min_load_addr_ff;
   logic [15:0] target_machine_ff;
   logic [1:0]  data_encoding_ff;

   // Pipeline registers
   logic           in_valid_ff, in_valid_in;
   logic           in_kind_ff;
   req_fields_type in_data_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_fields_type out_data_ff, out_data_in;

   // Checker state
   logic [15:0] remaining_ff, remaining_in;
   logic [63:0] last_start_ff, last_start_in;
   logic [63:0] high_end_ff, high_end_in;
   logic [63:0] entry_reg_ff, entry_reg_in;
   status_type  fail_code_ff, fail_code_in;
   logic        header_seen_ff, header_seen_in;

   // Check datapath
   logic        advance;
   status_type  hdr_status;
   status_type  seg_status;
   status_type  item_status;
   logic        seg_skip;
   logic [63:0] align_minus;
   logic [63:0] align_mask;
   logic [63:0] seg_start;
   logic [64:0] file_sum;
   logic [65:0] end_sum;
   logic [63:0] end_aligned;

   // Move the input stage into the result register when it is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_data_ff.done_res;
   assign rsp_tdata  = {4'b0000, out_data_ff.end_address, out_data_ff.entry_point,
                        out_data_ff.status};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_limit_ff      <= '0;
         min_load_addr_ff  <= '0;
         target_machine_ff <= RESET_MACHINE;
         data_encoding_ff  <= RESET_ENCODING;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEM_LIMIT:      mem_limit_ff      <= csr_wdata;
            CSR_MIN_LOAD_ADDR:  min_load_addr_ff  <= csr_wdata;
            CSR_TARGET_MACHINE: target_machine_ff <= csr_wdata[15:0];
            CSR_DATA_ENCODING:  data_encoding_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Segment arithmetic
   assign align_minus = in_data_ff.alignment - 64'd1;
   assign align_mask  = 64'd0 - in_data_ff.alignment;
   assign seg_start   = in_data_ff.address & align_mask;
   assign file_sum    = {1'b0, in_data_ff.address} + {1'b0, in_data_ff.file_bytes};
   assign end_sum     = {2'b00, in_data_ff.address} + {2'b00, in_data_ff.memory_bytes}
                        + {2'b00, align_minus};
   assign end_aligned = end_sum[63:0] & align_mask;
   assign seg_skip    = (in_data_ff.file_bytes == 64'd0) || (in_data_ff.type_code != PT_LOAD);

   // File header checks, first failing check wins
   always_comb begin
      if (in_data_ff.ident_word[31:0] != ELF_MAGIC ||
          in_data_ff.ident_word[39:32] != ELF_CLASS_64 ||
          in_data_ff.ident_word[47:40] != {6'b000000, data_encoding_ff} ||
          in_data_ff.format_version != ELF_VERSION) begin
         hdr_status = ST_IDENT;
      end else if (in_data_ff.header_size != ELF_HEADER_SIZE ||
                   in_data_ff.entry_count == 16'd0 ||
                   in_data_ff.entry_size != ELF_PHDR_SIZE) begin
         hdr_status = ST_SIZES;
      end else if (in_data_ff.type_code != ELF_TYPE_EXEC ||
                   in_data_ff.machine != target_machine_ff) begin
         hdr_status = ST_TYPE;
      end else if (in_data_ff.address < min_load_addr_ff ||
                   in_data_ff.address >= mem_limit_ff) begin
         hdr_status = ST_ENTRY;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // Loadable segment checks, first failing check wins
   always_comb begin
      if (in_data_ff.address < min_load_addr_ff) begin
         seg_status = ST_BELOW;
      end else if (in_data_ff.address < last_start_ff) begin
         seg_status = ST_UNSORTED;
      end else if (in_data_ff.alignment == 64'd0 ||
                   (in_data_ff.alignment & align_minus) != 64'd0) begin
         seg_status = ST_ALIGN;
      end else if (seg_start < min_load_addr_ff) begin
         seg_status = ST_BELOW;
      end else if (seg_start < high_end_ff) begin
         seg_status = ST_OVERLAP;
      end else if (in_data_ff.address >= mem_limit_ff ||
                   file_sum > {1'b0, mem_limit_ff}) begin
         seg_status = ST_FILE;
      end else if (in_data_ff.memory_bytes < in_data_ff.file_bytes) begin
         seg_status = ST_MEMSZ;
      end else if (end_sum[65:64] != 2'b00 || end_aligned > mem_limit_ff) begin
         seg_status = ST_END;
      end else begin
         seg_status = ST_OK;
      end
   end

   // Resolve item status and next state
   always_comb begin
      remaining_in   = remaining_ff;
      last_start_in  = last_start_ff;
      high_end_in    = high_end_ff;
      entry_reg_in   = entry_reg_ff;
      fail_code_in   = fail_code_ff;
      header_seen_in = header_seen_ff;

      if (fail_code_ff != ST_OK) begin
         item_status = fail_code_ff;
      end else if (in_kind_ff == KIND_FILE_HEADER) begin
         item_status = header_seen_ff ? ST_ORDER : hdr_status;
      end else if (!header_seen_ff || remaining_ff == 16'd0) begin
         item_status = ST_ORDER;
      end else if (seg_skip) begin
         item_status = ST_OK;
      end else begin
         item_status = seg_status;
      end

      // Commit state only for a passing item; a failure just latches its code
      if (advance && fail_code_ff == ST_OK) begin
         if (item_status != ST_OK) begin
            fail_code_in = item_status;
         end else if (in_kind_ff == KIND_FILE_HEADER) begin
            header_seen_in = 1'b1;
            entry_reg_in   = in_data_ff.address;
            remaining_in   = in_data_ff.entry_count;
            last_start_in  = '0;
            high_end_in    = '0;
         end else begin
            remaining_in = remaining_ff - 16'd1;
            if (!seg_skip) begin
               last_start_in = in_data_ff.address;
               if (end_aligned > high_end_ff) begin
                  high_end_in = end_aligned;
               end
            end
         end
      end

      // Build the result word
      if (item_status != ST_OK) begin
         out_data_in.status      = item_status;
         out_data_in.done_res    = 1'b1;
         out_data_in.entry_point = '0;
         out_data_in.end_address = '0;
      end else begin
         out_data_in.status      = ST_OK;
         out_data_in.done_res    = header_seen_in && (remaining_in == 16'd0);
         out_data_in.entry_point = entry_reg_in;
         out_data_in.end_address = high_end_in;
      end
   end

   // Stage valids: fill on accept, drain on advance or response take
   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         remaining_ff   <= '0;
         last_start_ff  <= '0;
         high_end_ff    <= '0;
         entry_reg_ff   <= '0;
         fail_code_ff   <= ST_OK;
         header_seen_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         remaining_ff   <= remaining_in;
         last_start_ff  <= last_start_in;
         high_end_ff    <= high_end_in;
         entry_reg_ff   <= entry_reg_in;
         fail_code_ff   <= fail_code_in;
         header_seen_ff <= header_seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_fields_type'(req_tdata);
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Checks
   `ESTC_ASSERT_IMPLIES(a_fail_word_zeroed, clock, reset, out_valid_ff && (out_data_ff.status != ST_OK), (out_data_ff.entry_point == 64'd0) && (out_data_ff.end_address == 64'd0) && out_data_ff.done_res, "failed result word carries nonzero payload or no done")
   `ESTC_ASSERT_NEXT(a_fail_sticky, clock, reset, fail_code_ff != ST_OK, fail_code_ff == $past(fail_code_ff), "failure code changed after being latched")
   `ESTC_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff, "input stage dropped an item that did not advance")
   `ESTC_ASSERT_ALWAYS(a_count_needs_header, clock, reset, (remaining_ff == 16'd0) || header_seen_ff, "segment count pending without an accepted header")

endmodule

`default_nettype wire
